/* sv/two_button_press_classifier_unit_defines.svh */
// Assertion macros shared by the checker of the two-button press classifier
`ifndef TWO_BUTTON_PRESS_CLASSIFIER_UNIT_DEFINES_SVH
`define TWO_BUTTON_PRESS_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define TBPC_ASSERT_IMP(lbl, clk, rst_n, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TBPC_ASSERT_NXT(lbl, clk, rst_n, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset
`define TBPC_ASSERT_ALWAYS_NXT(lbl, clk, cond, prop, msg) \
  lbl: assert property (@(posedge clk) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* sv/tbpc_pkg.sv */
// Types and constants of the two-button press classifier
`timescale 1ns / 1ps
package tbpc_pkg;

  // Operation codes of an input item
  localparam logic OP_SCAN   = 1'b0;
  localparam logic OP_RESYNC = 1'b1;

  // Result event codes
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_A_SHORT = 3'd1;
  localparam logic [2:0] EV_A_LONG  = 3'd2;
  localparam logic [2:0] EV_A_VLONG = 3'd3;
  localparam logic [2:0] EV_B_SHORT = 3'd4;
  localparam logic [2:0] EV_B_LONG  = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE_TICKS = 2'd0;
  localparam logic [1:0] CFG_LONG_PRESS     = 2'd1;
  localparam logic [1:0] CFG_VLONG_PRESS    = 2'd2;

  // Configuration reset values
  localparam logic [7:0]  DEBOUNCE_TICKS_RST = 8'd2;
  localparam logic [31:0] LONG_PRESS_RST     = 32'd800;
  localparam logic [31:0] VLONG_PRESS_RST    = 32'd3000;

  // Events one button raises on a scan
  typedef struct packed {
    logic ev_short;
    logic ev_long;
    logic ev_vlong;
  } scan_ev_t;

endpackage

/* sv/tbpc_if.sv */
// Valid/ready channel interfaces for input and result items
`timescale 1ns / 1ps
interface tbpc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] now_ms;
  logic        level_a;
  logic        level_b;

  modport source (output valid, operation, now_ms, level_a, level_b, input ready);
  modport sink   (input valid, operation, now_ms, level_a, level_b, output ready);
endinterface

interface tbpc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;

  modport source (output valid, event_res, input ready);
  modport sink   (input valid, event_res, output ready);
endinterface

/* sv/tbpc_button_scan.sv */
// Debounce and press-length state of one button
`timescale 1ns / 1ps
module tbpc_button_scan #(
  parameter int COUNT_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic              resync_en,
  input  logic              raw,
  input  logic [31:0]       now_ms,
  input  logic [7:0]        debounce_ticks,
  input  logic [31:0]       long_press_ms,
  input  logic [31:0]       very_long_press_ms,
  output tbpc_pkg::scan_ev_t ev
);
  import tbpc_pkg::*;

  localparam int CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic                  last_r, last_nxt;
  logic                  stable_r, stable_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [31:0]           start_r, start_nxt;
  logic                  long_done_r, long_done_nxt;
  logic                  vlong_done_r, vlong_done_nxt;

  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  settled;
  logic [31:0]           held;

  // Saturating sample count and threshold compare
  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign settled = CMP_W'(cnt_inc) >= CMP_W'(debounce_ticks);
  assign held    = now_ms - start_r;

  // Next state and events of a scan
  always_comb begin
    last_nxt       = last_r;
    stable_nxt     = stable_r;
    cnt_nxt        = cnt_r;
    start_nxt      = start_r;
    long_done_nxt  = long_done_r;
    vlong_done_nxt = vlong_done_r;
    ev             = '0;
    if (raw != last_r) begin
      last_nxt = raw;
      cnt_nxt  = '0;
    end else begin
      cnt_nxt = cnt_inc;
      if (settled) begin
        if (stable_r != raw) begin
          stable_nxt = raw;
          if (!raw) begin
            start_nxt      = now_ms;
            long_done_nxt  = 1'b0;
            vlong_done_nxt = 1'b0;
          end else begin
            start_nxt   = '0;
            ev.ev_short = !long_done_r;
          end
        end else if (!raw) begin
          if (!long_done_r && held >= long_press_ms) begin
            long_done_nxt = 1'b1;
            ev.ev_long    = 1'b1;
          end else if (long_done_r && !vlong_done_r && held >= very_long_press_ms) begin
            vlong_done_nxt = 1'b1;
            ev.ev_vlong    = 1'b1;
          end
        end
      end
    end
  end

  // Hold state, apply a resync or commit a scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r       <= 1'b1;
      stable_r     <= 1'b1;
      cnt_r        <= '0;
      start_r      <= '0;
      long_done_r  <= 1'b0;
      vlong_done_r <= 1'b0;
    end else if (resync_en) begin
      last_r   <= raw;
      stable_r <= raw;
      if (!raw) begin
        start_r     <= now_ms;
        long_done_r <= 1'b1;
      end
    end else if (step_en) begin
      last_r       <= last_nxt;
      stable_r     <= stable_nxt;
      cnt_r        <= cnt_nxt;
      start_r      <= start_nxt;
      long_done_r  <= long_done_nxt;
      vlong_done_r <= vlong_done_nxt;
    end
  end

endmodule

/* sv/two_button_press_classifier_unit.sv */
// Top level of the two-button press classifier
//
// Each input item is a tick with a millisecond timestamp and the raw
// active-low levels of buttons A and B, or a resync that takes the current
// levels as stable. Every item yields exactly one result item carrying an
// event code (none, A short/long/very long, B short/long). Items pass an
// input register and a result register, and a new item is accepted in
// every cycle while the result side takes its items; the button state
// update between the two registers, committed as each item is processed,
// sets that rate. Write configuration only while no item is in flight.
`timescale 1ns / 1ps
module two_button_press_classifier_unit #(
  parameter int COUNT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  tbpc_in_if.sink     in_item,
  tbpc_out_if.source  out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import tbpc_pkg::*;

  logic [7:0]  debounce_ticks_r;
  logic [31:0] long_press_r;
  logic [31:0] vlong_press_r;

  logic        s1_valid_r;
  logic        s1_op_r;
  logic [31:0] s1_now_r;
  logic        s1_lvl_a_r;
  logic        s1_lvl_b_r;

  logic        out_valid_r;
  logic [2:0]  out_event_r;
  logic [2:0]  event_nxt;

  logic        can_take;
  logic        proc;
  logic        scan_a;
  logic        scan_b;
  logic        resync;
  scan_ev_t    ev_a;
  scan_ev_t    ev_b;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= DEBOUNCE_TICKS_RST;
      long_press_r     <= LONG_PRESS_RST;
      vlong_press_r    <= VLONG_PRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_TICKS: debounce_ticks_r <= cfg_wdata[7:0];
        CFG_LONG_PRESS:     long_press_r     <= cfg_wdata;
        CFG_VLONG_PRESS:    vlong_press_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign can_take       = !out_valid_r || out_item.ready;
  assign proc           = s1_valid_r && can_take;
  assign in_item.ready  = !s1_valid_r || can_take;
  assign resync         = proc && (s1_op_r == OP_RESYNC);
  assign scan_a         = proc && (s1_op_r == OP_SCAN);
  // Skip button B on a tick where button A raised an event
  assign scan_b         = scan_a && !(ev_a.ev_short || ev_a.ev_long || ev_a.ev_vlong);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_item.ready) begin
      s1_valid_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      s1_op_r    <= in_item.operation;
      s1_now_r   <= in_item.now_ms;
      s1_lvl_a_r <= in_item.level_a;
      s1_lvl_b_r <= in_item.level_b;
    end
  end

  tbpc_button_scan #(.COUNT_BITS(COUNT_BITS)) u_scan_a (
    .clk                (clk),
    .rst_n              (rst_n),
    .step_en            (scan_a),
    .resync_en          (resync),
    .raw                (s1_lvl_a_r),
    .now_ms             (s1_now_r),
    .debounce_ticks     (debounce_ticks_r),
    .long_press_ms      (long_press_r),
    .very_long_press_ms (vlong_press_r),
    .ev                 (ev_a)
  );

  tbpc_button_scan #(.COUNT_BITS(COUNT_BITS)) u_scan_b (
    .clk                (clk),
    .rst_n              (rst_n),
    .step_en            (scan_b),
    .resync_en          (resync),
    .raw                (s1_lvl_b_r),
    .now_ms             (s1_now_r),
    .debounce_ticks     (debounce_ticks_r),
    .long_press_ms      (long_press_r),
    .very_long_press_ms (vlong_press_r),
    .ev                 (ev_b)
  );

  // Encode the event; button B reports very long with its long code
  always_comb begin
    event_nxt = EV_NONE;
    if (s1_op_r == OP_SCAN) begin
      if (ev_a.ev_short) begin
        event_nxt = EV_A_SHORT;
      end else if (ev_a.ev_long) begin
        event_nxt = EV_A_LONG;
      end else if (ev_a.ev_vlong) begin
        event_nxt = EV_A_VLONG;
      end else if (ev_b.ev_short) begin
        event_nxt = EV_B_SHORT;
      end else if (ev_b.ev_long || ev_b.ev_vlong) begin
        event_nxt = EV_B_LONG;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (can_take) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_event_r <= event_nxt;
    end
  end

  assign out_item.valid     = out_valid_r;
  assign out_item.event_res = out_event_r;

endmodule

/* sv/tbpc_checker.sv */
// Port-level checks of the two-button press classifier, bound to the top level
`timescale 1ns / 1ps
`include "two_button_press_classifier_unit_defines.svh"
module tbpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_event
);
  import tbpc_pkg::*;

  // A stalled result holds its value
  `TBPC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_event), "stalled result changed")

  // Only defined event codes leave the block
  `TBPC_ASSERT_IMP(a_ev_range, clk, rst_n, out_valid, out_event <= EV_B_LONG, "event code out of range")

  // Input back-pressure only when the result side is full and stalled
  `TBPC_ASSERT_IMP(a_stall_cause, clk, rst_n, !in_ready, out_valid && !out_ready, "input stalled without output stall")

  // No result right after reset
  `TBPC_ASSERT_ALWAYS_NXT(a_rst_empty, clk, !rst_n, !out_valid, "result valid after reset")

endmodule

bind two_button_press_classifier_unit tbpc_checker u_tbpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_item.ready),
  .out_valid (out_item.valid),
  .out_ready (out_item.ready),
  .out_event (out_item.event_res)
);

/* tb/sv/two_button_press_classifier_unit_tb.sv */
// Testbench for the two-button press classifier: driver, monitor and event predictor
`timescale 1ns / 1ps
module two_button_press_classifier_unit_tb;
  import tbpc_pkg::*;

  localparam int COUNT_BITS = 8;

  typedef struct packed {
    logic        op;
    logic [31:0] now;
    logic        lv_a;
    logic        lv_b;
  } tick_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_wdata;

  tbpc_in_if in_ch ();
  tbpc_out_if out_ch ();

  two_button_press_classifier_unit #(
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Configuration copy used by the predictor
  logic [7:0]  db_ticks;
  logic [31:0] long_ms;
  logic [31:0] vlong_ms;

  // Per-button debounce and press state, index 0 is A, 1 is B
  logic                  last_lv[2];
  logic                  stable_lv[2];
  logic [COUNT_BITS-1:0] same_cnt[2];
  logic [31:0]           press_t[2];
  logic                  long_fired[2];
  logic                  vlong_fired[2];

  tick_t       tick_q[$];
  logic [2:0]  event_q[$];
  tick_t       cur_tick;
  logic [2:0]  want_ev;
  logic [31:0] now_t;

  int unsigned n_queued;
  int unsigned n_accepted;
  int unsigned n_results;
  int unsigned n_errors;
  int unsigned n_settings;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned ev_seen[6];

  always #4 clk = ~clk;

  // Debounce one button and classify its press
  function automatic logic [2:0] scan_button(int unsigned b, logic raw, logic [31:0] now,
                                             logic [2:0] ev_s, logic [2:0] ev_l,
                                             logic [2:0] ev_v);
    logic [31:0] held;
    if (raw != last_lv[b]) begin
      last_lv[b] = raw;
      same_cnt[b] = '0;
      return EV_NONE;
    end
    if (same_cnt[b] != '1) same_cnt[b] = same_cnt[b] + 1'b1;
    if (same_cnt[b] < db_ticks) return EV_NONE;
    if (stable_lv[b] != raw) begin
      stable_lv[b] = raw;
      if (!raw) begin
        press_t[b] = now;
        long_fired[b] = 1'b0;
        vlong_fired[b] = 1'b0;
        return EV_NONE;
      end
      press_t[b] = '0;
      return long_fired[b] ? EV_NONE : ev_s;
    end
    if (!raw) begin
      held = now - press_t[b];
      if (!long_fired[b] && held >= long_ms) begin
        long_fired[b] = 1'b1;
        return ev_l;
      end
      if (long_fired[b] && !vlong_fired[b] && held >= vlong_ms) begin
        vlong_fired[b] = 1'b1;
        return ev_v;
      end
    end
    return EV_NONE;
  endfunction

  // Advance the button state by one item and return its event
  function automatic logic [2:0] classify_tick(tick_t t);
    logic [2:0] ev;
    logic       lv[2];
    lv[0] = t.lv_a;
    lv[1] = t.lv_b;
    ev = EV_NONE;
    if (t.op == OP_RESYNC) begin
      for (int b = 0; b < 2; b++) begin
        last_lv[b] = lv[b];
        stable_lv[b] = lv[b];
        if (!lv[b]) begin
          press_t[b] = t.now;
          long_fired[b] = 1'b1;
        end
      end
    end else begin
      ev = scan_button(0, t.lv_a, t.now, EV_A_SHORT, EV_A_LONG, EV_A_VLONG);
      // B is not scanned on a tick where A reports
      if (ev == EV_NONE) ev = scan_button(1, t.lv_b, t.now, EV_B_SHORT, EV_B_LONG, EV_B_LONG);
    end
    return ev;
  endfunction

  // Driver: predict on acceptance, hold on stall, otherwise issue or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        event_q.push_back(classify_tick(cur_tick));
        n_accepted++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the item until it is taken
      end else if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_tick = tick_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.operation <= cur_tick.op;
        in_ch.now_ms    <= cur_tick.now;
        in_ch.level_a   <= cur_tick.lv_a;
        in_ch.level_b   <= cur_tick.lv_b;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result item with the oldest expected event
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (event_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result item, expected none, got event %0d",
                   $time, out_ch.event_res);
        end else begin
          want_ev = event_q.pop_front();
          if (out_ch.event_res !== want_ev) begin
            n_errors++;
            $display("%0t: event_res mismatch, expected %0d, got %0d",
                     $time, want_ev, out_ch.event_res);
          end
          if (want_ev <= EV_B_LONG) ev_seen[want_ev]++;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_tick(logic op, logic [31:0] now, logic a, logic b);
    tick_t t;
    t.op = op;
    t.now = now;
    t.lv_a = a;
    t.lv_b = b;
    tick_q.push_back(t);
    n_queued++;
    now_t = now;
  endtask

  // Wait until every item is taken and every result has come back
  task automatic settle();
    while (n_accepted != n_queued || event_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEBOUNCE_TICKS: db_ticks = val[7:0];
      CFG_LONG_PRESS:     long_ms = val;
      CFG_VLONG_PRESS:    vlong_ms = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic [7:0] db, logic [31:0] lg, logic [31:0] vl);
    settle();
    write_reg(CFG_DEBOUNCE_TICKS, {24'd0, db});
    write_reg(CFG_LONG_PRESS, lg);
    write_reg(CFG_VLONG_PRESS, vl);
    n_settings++;
  endtask

  // One press of A, B or both: optional bounce, hold, then release
  task automatic add_press(int unsigned which);
    int unsigned n_hold, n_rel, n_bounce;
    longint unsigned lim, span, step;
    logic pa, pb;
    pa = (which != 1);
    pb = (which != 0);
    n_bounce = $urandom_range(3);
    n_hold = db_ticks + 1 + $urandom_range(5);
    n_rel = db_ticks + 1 + $urandom_range(3);
    case ($urandom_range(2))
      0: lim = long_ms;
      1: lim = vlong_ms;
      default: begin
        lim = vlong_ms;
        lim = lim * 2;
      end
    endcase
    if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
    span = $urandom_range(lim[31:0]);
    step = span / n_hold;
    repeat (n_bounce) begin
      push_tick(OP_SCAN, now_t + 1, pa ? 1'($urandom_range(1)) : 1'b1,
                pb ? 1'($urandom_range(1)) : 1'b1);
    end
    repeat (n_hold) push_tick(OP_SCAN, now_t + step[31:0] + $urandom_range(3), !pa, !pb);
    repeat (n_rel) push_tick(OP_SCAN, now_t + $urandom_range(1, 20), 1'b1, 1'b1);
  endtask

  // Mostly well-formed presses, the rest noise, resyncs and time jumps
  task automatic fill_random(int unsigned budget);
    int unsigned start_cnt, pick;
    start_cnt = n_queued;
    while (n_queued - start_cnt < budget) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        add_press($urandom_range(2));
      end else if (pick < 87) begin
        repeat ($urandom_range(1, 6))
          push_tick(OP_SCAN, now_t + $urandom_range(50), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
      end else if (pick < 94) begin
        push_tick(OP_RESYNC, now_t + $urandom_range(50), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end else begin
        push_tick(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end
    end
  endtask

  task automatic run_phase(logic [7:0] db, logic [31:0] lg, logic [31:0] vl,
                           int unsigned s_pct, int unsigned r_pct, int unsigned budget);
    configure(db, lg, vl);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    fill_random(budget / 2);
    // hold the sender off until all results are back
    settle();
    fill_random(budget - budget / 2);
  endtask

  initial begin
    logic [31:0] t0;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_DEBOUNCE_TICKS;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_SCAN;
    in_ch.now_ms = '0;
    in_ch.level_a = 1'b1;
    in_ch.level_b = 1'b1;
    out_ch.ready = 1'b0;
    cur_tick = '0;
    now_t = '0;
    n_queued = 0;
    n_accepted = 0;
    n_results = 0;
    n_errors = 0;
    n_settings = 1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (ev_seen[i]) ev_seen[i] = 0;
    db_ticks = DEBOUNCE_TICKS_RST;
    long_ms = LONG_PRESS_RST;
    vlong_ms = VLONG_PRESS_RST;
    for (int b = 0; b < 2; b++) begin
      last_lv[b] = 1'b1;
      stable_lv[b] = 1'b1;
      same_cnt[b] = '0;
      press_t[b] = '0;
      long_fired[b] = 1'b0;
      vlong_fired[b] = 1'b0;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // A held through long and very long across the time wrap, no short after
    push_tick(OP_SCAN, 32'hFFFF_FFF0, 1'b1, 1'b1);
    push_tick(OP_SCAN, 32'hFFFF_FFF8, 1'b0, 1'b1);
    push_tick(OP_SCAN, 32'hFFFF_FFFC, 1'b0, 1'b1);
    push_tick(OP_SCAN, 32'hFFFF_FFFF, 1'b0, 1'b1);
    push_tick(OP_SCAN, 32'h0000_031F, 1'b0, 1'b1);
    push_tick(OP_SCAN, 32'h0000_0BB7, 1'b0, 1'b1);
    repeat (3) push_tick(OP_SCAN, now_t + 1, 1'b1, 1'b1);
    // short press of A
    repeat (3) push_tick(OP_SCAN, now_t + 1, 1'b0, 1'b1);
    repeat (3) push_tick(OP_SCAN, now_t + 1, 1'b1, 1'b1);
    // B held: its very-long press reports the long code
    repeat (3) push_tick(OP_SCAN, now_t + 1, 1'b1, 1'b0);
    t0 = now_t;
    push_tick(OP_SCAN, t0 + LONG_PRESS_RST, 1'b1, 1'b0);
    push_tick(OP_SCAN, t0 + VLONG_PRESS_RST, 1'b1, 1'b0);
    // both held: A reports long, B is skipped that tick
    repeat (3) push_tick(OP_SCAN, now_t + 1, 1'b0, 1'b0);
    push_tick(OP_SCAN, now_t + LONG_PRESS_RST, 1'b0, 1'b0);
    // resync marks held A as already long, so only very long follows
    push_tick(OP_RESYNC, now_t + 5, 1'b0, 1'b1);
    push_tick(OP_SCAN, now_t + VLONG_PRESS_RST, 1'b0, 1'b1);
    push_tick(OP_SCAN, 32'h0000_0000, 1'b1, 1'b1);
    push_tick(OP_SCAN, 32'h0000_0001, 1'b1, 1'b1);

    run_phase(DEBOUNCE_TICKS_RST, LONG_PRESS_RST, VLONG_PRESS_RST, 0, 0, 160);
    run_phase(8'd1, 32'd1, 32'd1, 81, 0, 160);
    // zero threshold passes on every equal sample
    run_phase(8'd0, 32'd50, 32'd120, 0, 81, 160);
    run_phase(8'($urandom_range(1, 8)), $urandom_range(1, 400), $urandom_range(1, 900),
              26, 26, 160);

    // widest settings: count saturation and a full-range held time
    configure(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    t0 = $urandom;
    repeat (300) push_tick(OP_SCAN, t0, 1'b0, 1'b1);
    repeat (2) push_tick(OP_SCAN, t0 - 1, 1'b0, 1'b1);
    repeat (258) push_tick(OP_SCAN, t0, 1'b1, 1'b1);

    run_phase(8'($urandom_range(1, 4)), $urandom | 32'd1, $urandom | 32'd1, 0, 81, 160);
    run_phase(DEBOUNCE_TICKS_RST, LONG_PRESS_RST, VLONG_PRESS_RST, 26, 26, 160);

    settle();
    $display("covered %0d items and %0d results over %0d register settings",
             n_accepted, n_results, n_settings);
    $display("events seen: A short %0d, A long %0d, A very long %0d, B short %0d, B long %0d",
             ev_seen[EV_A_SHORT], ev_seen[EV_A_LONG], ev_seen[EV_A_VLONG],
             ev_seen[EV_B_SHORT], ev_seen[EV_B_LONG]);
    if (n_errors == 0 && event_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #3200000;
    $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/tbpc_pkg.sv
sv/tbpc_if.sv
sv/tbpc_button_scan.sv
sv/two_button_press_classifier_unit.sv
sv/tbpc_checker.sv
tb/sv/two_button_press_classifier_unit_tb.sv
